@@ sv/euler_camera_pose_update_defines.svh @@
// assertion macros for the camera pose block
// no dependencies; taken in by the top level
`ifndef EULER_CAMERA_POSE_UPDATE_DEFINES_SVH
`define EULER_CAMERA_POSE_UPDATE_DEFINES_SVH

// same-cycle implication
`define ECPU_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ECPU_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/ecpu_pkg.sv @@
// shared types, constants and the arctangent table of the camera pose block
// no dependencies
`default_nettype none

package ecpu_pkg;

  localparam int FRAC   = 16;
  localparam int ANG_W  = 29;
  localparam int VEC_W  = 18;
  localparam int MUL_W  = 26;
  localparam int PROD_W = 2 * MUL_W;
  localparam int CORDIC_MAX = 24;
  localparam int CIDX_W = 5;
  localparam int Z_W    = 33;
  localparam int ZSH    = 24 - FRAC;
  localparam int RSH    = 30 - FRAC;

  localparam logic signed [ANG_W-1:0] DEG_P180 = 29'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG_M180 = -29'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG_360  = 29'sd23592960;
  localparam logic signed [ANG_W-1:0] DEG_P90  = 29'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG_M90  = -29'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG_P89  = 29'sd5832704;
  localparam logic signed [ANG_W-1:0] DEG_M89  = -29'sd5832704;

  localparam logic [22:0] FOV_MIN   = 23'd1310720;
  localparam logic [22:0] FOV_MAX   = 23'd5898240;
  localparam logic [22:0] FOV_RESET = 23'd3932160;

  localparam logic signed [VEC_W-1:0] VEC_ONE = 18'sd65536;
  localparam logic signed [Z_W-1:0]   CORDIC_K = 33'sd652032874;

  localparam logic signed [31:0] RST_POS_X = 32'sd0;
  localparam logic signed [31:0] RST_POS_Y = 32'sd111411;
  localparam logic signed [31:0] RST_POS_Z = 32'sd0;
  localparam logic signed [24:0] RST_YAW   = -25'sd5898240;
  localparam logic signed [23:0] RST_PITCH = 24'sd0;
  localparam logic [23:0] RST_SPEED = 24'd163840;
  localparam logic [15:0] RST_SENS  = 16'd6554;

  localparam logic [1:0] ACT_MOVE = 2'd0;
  localparam logic [1:0] ACT_LOOK = 2'd1;
  localparam logic [1:0] ACT_ZOOM = 2'd2;

  localparam logic [2:0] DIR_FWD   = 3'd0;
  localparam logic [2:0] DIR_BACK  = 3'd1;
  localparam logic [2:0] DIR_LEFT  = 3'd2;
  localparam logic [2:0] DIR_RIGHT = 3'd3;
  localparam logic [2:0] DIR_UP    = 3'd4;
  localparam logic [2:0] DIR_DOWN  = 3'd5;

  localparam logic [2:0] REG_POS_X = 3'd0;
  localparam logic [2:0] REG_POS_Y = 3'd1;
  localparam logic [2:0] REG_POS_Z = 3'd2;
  localparam logic [2:0] REG_YAW   = 3'd3;
  localparam logic [2:0] REG_PITCH = 3'd4;
  localparam logic [2:0] REG_SPEED = 3'd5;
  localparam logic [2:0] REG_SENS  = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_VEL, ST_VEL_CAP, ST_MV_MUL, ST_MV_ACC, ST_LK_MX, ST_LK_MY,
    ST_LK_UPD, ST_WRAP, ST_COR_Y, ST_COR_P, ST_VM_MUL, ST_VM_CAP, ST_VEC, ST_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic signed [24:0] angle;
  } cor_req_t;

  function automatic logic [31:0] atan_q24(input logic [CIDX_W-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd754974720;
      5'd1:  r = 32'd445687602;
      5'd2:  r = 32'd235489088;
      5'd3:  r = 32'd119537938;
      5'd4:  r = 32'd60000934;
      5'd5:  r = 32'd30029717;
      5'd6:  r = 32'd15018523;
      5'd7:  r = 32'd7509720;
      5'd8:  r = 32'd3754917;
      5'd9:  r = 32'd1877466;
      5'd10: r = 32'd938734;
      5'd11: r = 32'd469367;
      5'd12: r = 32'd234684;
      5'd13: r = 32'd117342;
      5'd14: r = 32'd58671;
      5'd15: r = 32'd29335;
      5'd16: r = 32'd14668;
      5'd17: r = 32'd7334;
      5'd18: r = 32'd3667;
      5'd19: r = 32'd1833;
      5'd20: r = 32'd917;
      5'd21: r = 32'd458;
      5'd22: r = 32'd229;
      5'd23: r = 32'd115;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/ecpu_chan_if.sv @@
// valid/ready channel interfaces for action items and pose results
// no dependencies
`default_nettype none

interface ecpu_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [2:0]        direction;
  logic [15:0]       delta_time;
  logic signed [15:0] x_delta;
  logic signed [15:0] y_delta;
  logic              constrain_pitch;

  modport source (output valid, action, direction, delta_time, x_delta, y_delta,
                  constrain_pitch, input ready);
  modport sink   (input valid, action, direction, delta_time, x_delta, y_delta,
                  constrain_pitch, output ready);
endinterface

interface ecpu_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [17:0] front_x;
  logic signed [17:0] front_y;
  logic signed [17:0] front_z;
  logic signed [17:0] right_x;
  logic signed [17:0] right_z;
  logic signed [17:0] up_x;
  logic signed [17:0] up_y;
  logic signed [17:0] up_z;
  logic [22:0]       field_of_view;

  modport source (output valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                  right_x, right_z, up_x, up_y, up_z, field_of_view, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                  right_x, right_z, up_x, up_y, up_z, field_of_view, output ready);
endinterface

`default_nettype wire

@@ sv/ecpu_mul.sv @@
// shared signed multiplier with registered product
// depends on ecpu_pkg
`default_nettype none

module ecpu_mul
  import ecpu_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [MUL_W-1:0]  a,
  input  wire logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0]      prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

`default_nettype wire

@@ sv/ecpu_cordic.sv @@
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on ecpu_pkg
`default_nettype none

module ecpu_cordic
  import ecpu_pkg::*;
#(
  parameter int STEPS = 18
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cor_req_t          req,
  output logic                   done_r,
  output logic signed [VEC_W-1:0] sin_o,
  output logic signed [VEC_W-1:0] cos_o
);

  localparam int N = (STEPS > CORDIC_MAX) ? CORDIC_MAX : STEPS;
  localparam logic signed [Z_W-1:0] HALF = 33'sd1 <<< (RSH - 1);
  localparam logic signed [Z_W-1:0] ONE_Z = 33'sd1 <<< FRAC;

  logic signed [Z_W-1:0] x_r, y_r, z_r;
  logic [CIDX_W-1:0]     i_r;
  logic                  busy_r, flip_r;

  logic signed [ANG_W-1:0] a_w, a_f;
  logic                    flip_in;
  logic signed [Z_W-1:0]   z0, dx, dy, at, xs, ys, xc, yc;

  // fold into +-90 degrees, negating both results afterwards
  always_comb begin
    a_w = ANG_W'(req.angle);
    flip_in = 1'b0;
    a_f = a_w;
    if (a_w > DEG_P90) begin
      a_f = a_w - DEG_P180;
      flip_in = 1'b1;
    end else if (a_w < DEG_M90) begin
      a_f = a_w + DEG_P180;
      flip_in = 1'b1;
    end
    z0 = Z_W'(a_f) <<< ZSH;
    dx = y_r >>> i_r;
    dy = x_r >>> i_r;
    at = $signed({1'b0, atan_q24(i_r)});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      if (i_r == CIDX_W'(N - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r    <= CORDIC_K;
      y_r    <= '0;
      z_r    <= z0;
      i_r    <= '0;
      flip_r <= flip_in;
    end else if (busy_r) begin
      if (!z_r[Z_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
      i_r <= i_r + 1'b1;
    end
  end

  // round to the vector format and clamp to unit length
  always_comb begin
    xs = (x_r + HALF) >>> RSH;
    ys = (y_r + HALF) >>> RSH;
    xc = (xs > ONE_Z) ? ONE_Z : ((xs < -ONE_Z) ? -ONE_Z : xs);
    yc = (ys > ONE_Z) ? ONE_Z : ((ys < -ONE_Z) ? -ONE_Z : ys);
    cos_o = flip_r ? -VEC_W'(xc) : VEC_W'(xc);
    sin_o = flip_r ? -VEC_W'(yc) : VEC_W'(yc);
  end

endmodule

`default_nettype wire

@@ sv/euler_camera_pose_update.sv @@
// first-person camera pose: sequencer, pose registers and register port
// depends on ecpu_pkg, ecpu_chan_if, ecpu_mul, ecpu_cordic and the defines header
//
//  channel  | direction | handshake         | carries
//  in_if    | in        | valid/ready       | action, direction, time, mouse deltas
//  out_if   | out       | valid/ready       | position, front/right/up, field of view
//  apb      | in        | psel/penable      | start pose, speed, sensitivity
//
// one item at a time; zoom and the unused action go straight to the output stage,
// a look takes two cordic runs plus the angle wraps; the cordic loop and the one
// shared multiplier set how long each item takes
// after reset the vectors are computed first (ready low); a start yaw or pitch
// write restarts that computation
// a finished result waits in the output register; the next item is taken meanwhile
`default_nettype none
`include "euler_camera_pose_update_defines.svh"

module euler_camera_pose_update
  import ecpu_pkg::*;
#(
  parameter int CORDIC_STEPS = 18
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ecpu_in_if.sink          in_if,
  ecpu_out_if.source       out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic signed [PROD_W-1:0] HALF16 = 52'sd32768;
  localparam logic signed [PROD_W-1:0] HALF4  = 52'sd8;
  localparam logic signed [33:0] POS_MAX = 34'sd2147483647;
  localparam logic signed [33:0] POS_MIN = -34'sd2147483648;

  state_t state_r, state_nxt;

  // register file
  logic signed [31:0] st_px_r, st_py_r, st_pz_r;
  logic signed [24:0] st_yaw_r;
  logic signed [23:0] st_pitch_r;
  logic [23:0]        speed_r;
  logic [15:0]        sens_r;

  // pose
  logic signed [31:0] pos_x_r, pos_y_r, pos_z_r;
  logic signed [ANG_W-1:0] yaw_r, pitch_r;
  logic [22:0]        fov_r;
  logic signed [VEC_W-1:0] front_x_r, front_y_r, front_z_r, right_x_r, right_z_r;
  logic signed [VEC_W-1:0] up_x_r, up_y_r, up_z_r;

  // working registers
  logic               item_r;
  logic [1:0]         cnt_r;
  logic [2:0]         dir_r;
  logic [15:0]        dt_r;
  logic signed [15:0] xd_r, yd_r;
  logic               con_r;
  logic signed [MUL_W-1:0] vel_r;
  logic signed [27:0] rx_r;
  logic signed [VEC_W-1:0] sy_r, cy_r, sp_r, cp_r;
  logic signed [VEC_W-1:0] cycp_r, sycp_r, cysp_r, sysp_r;
  logic               out_valid_r;

  logic               cfg_wr, ang_wr, acc, out_load, in_range;
  logic [2:0]         idx;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] p16, p4;
  cor_req_t           cor_req;
  logic               cor_done;
  logic signed [VEC_W-1:0] cor_sin, cor_cos;

  logic signed [VEC_W-1:0] comp;
  logic               mv_en, mv_neg;
  logic signed [31:0] pos_sel;
  logic signed [33:0] d34, psum, psat;
  logic signed [29:0] fv;
  logic signed [ANG_W-1:0] ry, pnew;

  ecpu_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (mul_p)
  );

  ecpu_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (cor_req),
    .done_r (cor_done),
    .sin_o  (cor_sin),
    .cos_o  (cor_cos)
  );

  // register port: writes land on the access phase
  assign cfg_wr = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign ang_wr = cfg_wr && (idx == REG_YAW || idx == REG_PITCH);
  assign pready = 1'b1;

  always_comb begin
    case (idx)
      REG_POS_X: prdata = st_px_r;
      REG_POS_Y: prdata = st_py_r;
      REG_POS_Z: prdata = st_pz_r;
      REG_YAW:   prdata = 32'(st_yaw_r);
      REG_PITCH: prdata = 32'(st_pitch_r);
      REG_SPEED: prdata = {8'd0, speed_r};
      REG_SENS:  prdata = {16'd0, sens_r};
      default:   prdata = '0;
    endcase
  end

  assign in_if.ready = (state_r == ST_IDLE) && !ang_wr;
  assign acc         = in_if.valid && in_if.ready;
  assign out_load    = (state_r == ST_OUT) && (!out_valid_r || out_if.ready);

  // rounded forms of the product
  assign p16 = (mul_p + HALF16) >>> FRAC;
  assign p4  = (mul_p + HALF4) >>> 4;

  // move: which component drives position lane cnt_r
  always_comb begin
    comp   = '0;
    mv_en  = 1'b0;
    mv_neg = dir_r[0];
    if (dir_r == DIR_FWD || dir_r == DIR_BACK) begin
      mv_en = 1'b1;
      case (cnt_r)
        2'd0:    comp = front_x_r;
        2'd1:    comp = front_y_r;
        default: comp = front_z_r;
      endcase
    end else if (dir_r == DIR_LEFT || dir_r == DIR_RIGHT) begin
      // strafing runs against the right vector for left
      mv_neg = !dir_r[0];
      mv_en  = (cnt_r != 2'd1);
      comp   = (cnt_r == 2'd0) ? right_x_r : right_z_r;
    end else if (dir_r == DIR_UP || dir_r == DIR_DOWN) begin
      mv_en = (cnt_r == 2'd1);
      comp  = VEC_ONE;
    end
    case (cnt_r)
      2'd0:    pos_sel = pos_x_r;
      2'd1:    pos_sel = pos_y_r;
      default: pos_sel = pos_z_r;
    endcase
    d34  = 34'(p16);
    psum = 34'(pos_sel) + (mv_neg ? -d34 : d34);
    psat = (psum > POS_MAX) ? POS_MAX : ((psum < POS_MIN) ? POS_MIN : psum);
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_VEL: begin
        mul_a = $signed({2'b00, speed_r});
        mul_b = $signed({10'd0, dt_r});
      end
      ST_MV_MUL: begin
        mul_a = MUL_W'(comp);
        mul_b = vel_r;
      end
      ST_LK_MX: begin
        mul_a = MUL_W'(xd_r);
        mul_b = $signed({10'd0, sens_r});
      end
      ST_LK_MY: begin
        mul_a = MUL_W'(yd_r);
        mul_b = $signed({10'd0, sens_r});
      end
      ST_VM_MUL: begin
        mul_a = (cnt_r[0]) ? MUL_W'(sy_r) : MUL_W'(cy_r);
        mul_b = (cnt_r[1]) ? MUL_W'(sp_r) : MUL_W'(cp_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // look: new pitch, clamped or left for the wrap pass
  always_comb begin
    ry   = ANG_W'(28'(p4));
    pnew = pitch_r + ry;
    if (con_r) begin
      if (pnew > DEG_P89) begin
        pnew = DEG_P89;
      end else if (pnew < DEG_M89) begin
        pnew = DEG_M89;
      end
    end
  end

  assign in_range = (yaw_r < DEG_P180) && (yaw_r >= DEG_M180) &&
                    (pitch_r < DEG_P180) && (pitch_r >= DEG_M180);

  // zoom is a shift, subtract and clamp
  assign fv = $signed({7'd0, fov_r}) - (30'(in_if.y_delta) <<< (FRAC - 4));

  // cordic requests: yaw when the angles settle, pitch when yaw is done
  always_comb begin
    cor_req.start = 1'b0;
    cor_req.angle = 25'(yaw_r);
    if (state_r == ST_WRAP && in_range && !ang_wr) begin
      cor_req.start = 1'b1;
    end else if (state_r == ST_COR_Y && cor_done && !ang_wr) begin
      cor_req.start = 1'b1;
      cor_req.angle = 25'(pitch_r);
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_if.action)
            ACT_MOVE: state_nxt = ST_VEL;
            ACT_LOOK: state_nxt = ST_LK_MX;
            default:  state_nxt = ST_OUT;
          endcase
        end
      end
      ST_VEL:     state_nxt = ST_VEL_CAP;
      ST_VEL_CAP: state_nxt = ST_MV_MUL;
      ST_MV_MUL:  state_nxt = ST_MV_ACC;
      ST_MV_ACC:  state_nxt = (cnt_r == 2'd2) ? ST_OUT : ST_MV_MUL;
      ST_LK_MX:   state_nxt = ST_LK_MY;
      ST_LK_MY:   state_nxt = ST_LK_UPD;
      ST_LK_UPD:  state_nxt = ST_WRAP;
      ST_WRAP:    state_nxt = in_range ? ST_COR_Y : ST_WRAP;
      ST_COR_Y:   state_nxt = cor_done ? ST_COR_P : ST_COR_Y;
      ST_COR_P:   state_nxt = cor_done ? ST_VM_MUL : ST_COR_P;
      ST_VM_MUL:  state_nxt = ST_VM_CAP;
      ST_VM_CAP:  state_nxt = (cnt_r == 2'd3) ? ST_VEC : ST_VM_MUL;
      ST_VEC:     state_nxt = item_r ? ST_OUT : ST_IDLE;
      ST_OUT:     state_nxt = out_load ? ST_IDLE : ST_OUT;
      default:    state_nxt = ST_IDLE;
    endcase
    // a new start angle restarts the vector computation
    if (ang_wr) begin
      state_nxt = ST_WRAP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WRAP;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control and pose registers with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_px_r     <= RST_POS_X;
      st_py_r     <= RST_POS_Y;
      st_pz_r     <= RST_POS_Z;
      st_yaw_r    <= RST_YAW;
      st_pitch_r  <= RST_PITCH;
      speed_r     <= RST_SPEED;
      sens_r      <= RST_SENS;
      pos_x_r     <= RST_POS_X;
      pos_y_r     <= RST_POS_Y;
      pos_z_r     <= RST_POS_Z;
      yaw_r       <= ANG_W'(RST_YAW);
      pitch_r     <= ANG_W'(RST_PITCH);
      fov_r       <= FOV_RESET;
      item_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end

      case (state_r)
        ST_IDLE: begin
          if (acc) begin
            item_r <= 1'b1;
            if (in_if.action == ACT_ZOOM) begin
              if (fv < $signed({7'd0, FOV_MIN})) begin
                fov_r <= FOV_MIN;
              end else if (fv > $signed({7'd0, FOV_MAX})) begin
                fov_r <= FOV_MAX;
              end else begin
                fov_r <= 23'(fv);
              end
            end
          end
        end
        ST_VEL_CAP: cnt_r <= '0;
        ST_MV_ACC: begin
          if (mv_en) begin
            case (cnt_r)
              2'd0:    pos_x_r <= 32'(psat);
              2'd1:    pos_y_r <= 32'(psat);
              default: pos_z_r <= 32'(psat);
            endcase
          end
          cnt_r <= cnt_r + 2'd1;
        end
        ST_LK_UPD: begin
          yaw_r   <= yaw_r + ANG_W'(rx_r);
          pitch_r <= pnew;
        end
        ST_WRAP: begin
          // one step of the wrap into [-180, 180) per cycle
          if (yaw_r >= DEG_P180) begin
            yaw_r <= yaw_r - DEG_360;
          end else if (yaw_r < DEG_M180) begin
            yaw_r <= yaw_r + DEG_360;
          end
          if (pitch_r >= DEG_P180) begin
            pitch_r <= pitch_r - DEG_360;
          end else if (pitch_r < DEG_M180) begin
            pitch_r <= pitch_r + DEG_360;
          end
        end
        ST_COR_P: cnt_r <= '0;
        ST_VM_CAP: cnt_r <= cnt_r + 2'd1;
        ST_OUT: begin
          if (out_load) begin
            item_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase

      // register writes take effect last
      if (cfg_wr) begin
        case (idx)
          REG_POS_X: begin
            st_px_r <= $signed(pwdata);
            pos_x_r <= $signed(pwdata);
          end
          REG_POS_Y: begin
            st_py_r <= $signed(pwdata);
            pos_y_r <= $signed(pwdata);
          end
          REG_POS_Z: begin
            st_pz_r <= $signed(pwdata);
            pos_z_r <= $signed(pwdata);
          end
          REG_YAW: begin
            st_yaw_r <= $signed(pwdata[24:0]);
            yaw_r    <= ANG_W'($signed(pwdata[24:0]));
            item_r   <= 1'b0;
          end
          REG_PITCH: begin
            st_pitch_r <= $signed(pwdata[23:0]);
            pitch_r    <= ANG_W'($signed(pwdata[23:0]));
            item_r     <= 1'b0;
          end
          REG_SPEED: speed_r <= pwdata[23:0];
          REG_SENS:  sens_r  <= pwdata[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (acc) begin
      dir_r <= in_if.direction;
      dt_r  <= in_if.delta_time;
      xd_r  <= in_if.x_delta;
      yd_r  <= in_if.y_delta;
      con_r <= in_if.constrain_pitch;
    end
    case (state_r)
      ST_VEL_CAP: vel_r <= MUL_W'(p16);
      ST_LK_MY:   rx_r  <= 28'(p4);
      ST_COR_Y: begin
        if (cor_done) begin
          sy_r <= cor_sin;
          cy_r <= cor_cos;
        end
      end
      ST_COR_P: begin
        if (cor_done) begin
          sp_r <= cor_sin;
          cp_r <= cor_cos;
        end
      end
      ST_VM_CAP: begin
        case (cnt_r)
          2'd0:    cycp_r <= VEC_W'(p16);
          2'd1:    sycp_r <= VEC_W'(p16);
          2'd2:    cysp_r <= VEC_W'(p16);
          default: sysp_r <= VEC_W'(p16);
        endcase
      end
      ST_VEC: begin
        // a negative cos pitch turns right and up round
        front_x_r <= cycp_r;
        front_y_r <= sp_r;
        front_z_r <= sycp_r;
        right_x_r <= cp_r[VEC_W-1] ? sy_r : -sy_r;
        right_z_r <= cp_r[VEC_W-1] ? -cy_r : cy_r;
        up_x_r    <= cp_r[VEC_W-1] ? cysp_r : -cysp_r;
        up_y_r    <= cp_r[VEC_W-1] ? -cp_r : cp_r;
        up_z_r    <= cp_r[VEC_W-1] ? sysp_r : -sysp_r;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_if.pos_x         <= pos_x_r;
      out_if.pos_y         <= pos_y_r;
      out_if.pos_z         <= pos_z_r;
      out_if.front_x       <= front_x_r;
      out_if.front_y       <= front_y_r;
      out_if.front_z       <= front_z_r;
      out_if.right_x       <= right_x_r;
      out_if.right_z       <= right_z_r;
      out_if.up_x          <= up_x_r;
      out_if.up_y          <= up_y_r;
      out_if.up_z          <= up_z_r;
      out_if.field_of_view <= fov_r;
    end
  end

  assign out_if.valid = out_valid_r;

  `ECPU_ASSERT_IMP(a_fov_range, clk, rst_n, 1'b1, (fov_r >= FOV_MIN && fov_r <= FOV_MAX), "field of view left its range")
  `ECPU_ASSERT_NXT(a_acc_busy, clk, rst_n, acc, (state_r != ST_IDLE), "sequencer idle after a transfer in")
  `ECPU_ASSERT_NXT(a_out_load, clk, rst_n, out_load, out_valid_r, "result not presented after load")

endmodule

`default_nettype wire
